// ===== design/sgdm_pkg.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// sgdm_pkg
// Shared widths, register codes, reset values and saturation helper for the
// momentum update engine.
// ----------------------------------------------------------------------------
package sgdm_pkg;

  // default velocity store depth
  localparam int ELEMENT_COUNT_DEF = 4096;

  // field widths
  localparam int IDX_W   = 12;
  localparam int VAL_W   = 32;
  localparam int FAC_W   = 16;
  localparam int MODE_W  = 2;
  localparam int CIDX_W  = 2;
  localparam int IN_TD_W  = 80;
  localparam int OUT_TD_W = 48;

  // product widths: unsigned Q0.16 factor times signed Q16.16 value
  localparam int PROD_W = FAC_W + 1 + VAL_W;

  // register reset values
  localparam logic [FAC_W-1:0] LR_RST    = 16'd655;
  localparam logic [FAC_W-1:0] MOM_RST   = 16'd58982;
  localparam logic [FAC_W-1:0] DECAY_RST = 16'd0;

  // register indexes
  typedef enum logic [CIDX_W-1:0] {
    CFG_LR    = 2'd0,
    CFG_MOM   = 2'd1,
    CFG_DECAY = 2'd2,
    CFG_MODE  = 2'd3
  } cfg_idx_t;

  // weight decay selection
  typedef enum logic [MODE_W-1:0] {
    REG_NONE = 2'd0,
    REG_L1   = 2'd1,
    REG_L2   = 2'd2,
    REG_L1L2 = 2'd3
  } reg_mode_t;

  // clipped value with its clip flag
  typedef struct packed {
    logic                    clip;
    logic signed [VAL_W-1:0] value;
  } sat_t;

  // clip a wide signed value to 32 bits
  function automatic sat_t sat32(input logic signed [63:0] x);
    sat_t r;
    if (x > 64'sd2147483647) begin
      r.clip  = 1'b1;
      r.value = 32'sh7FFF_FFFF;
    end else if (x < -64'sd2147483648) begin
      r.clip  = 1'b1;
      r.value = 32'sh8000_0000;
    end else begin
      r.clip  = 1'b0;
      r.value = x[VAL_W-1:0];
    end
    return r;
  endfunction

endpackage

// ===== design/sgdm_vel_store.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// sgdm_vel_store
// Velocity memory: one registered read port, one write port, and a zeroing
// sweep over every entry after reset.
// ----------------------------------------------------------------------------
module sgdm_vel_store #(
  parameter int ELEMENT_COUNT = sgdm_pkg::ELEMENT_COUNT_DEF,
  parameter int AW            = (ELEMENT_COUNT > 1) ? $clog2(ELEMENT_COUNT) : 1
) (
  input  logic                           clk,
  input  logic                           rst,
  input  logic                           rd_en,
  input  logic [AW-1:0]                  rd_addr,
  output logic [sgdm_pkg::VAL_W-1:0]     rd_data,
  input  logic                           wr_en,
  input  logic [AW-1:0]                  wr_addr,
  input  logic [sgdm_pkg::VAL_W-1:0]     wr_data,
  output logic                           busy
);

  localparam logic [AW-1:0] LAST_ADDR = AW'(ELEMENT_COUNT - 1);

  logic [sgdm_pkg::VAL_W-1:0] mem [ELEMENT_COUNT];
  logic [AW-1:0]              clr_addr;
  logic                       clearing;

  logic                       we;
  logic [AW-1:0]              wa;
  logic [sgdm_pkg::VAL_W-1:0] wd;

  // clearing sweep owns the write port while it runs
  always_comb begin
    if (clearing) begin
      we = 1'b1;
      wa = clr_addr;
      wd = '0;
    end else begin
      we = wr_en;
      wa = wr_addr;
      wd = wr_data;
    end
  end

  // sweep counter, one entry per cycle
  always_ff @(posedge clk) begin
    if (rst) begin
      clearing <= 1'b1;
      clr_addr <= '0;
    end else if (clearing) begin
      if (clr_addr == LAST_ADDR) begin
        clearing <= 1'b0;
      end
      clr_addr <= clr_addr + AW'(1);
    end
  end

  // memory array, read before write at the same edge
  always_ff @(posedge clk) begin
    if (rd_en) begin
      rd_data <= mem[rd_addr];
    end
    if (we) begin
      mem[wa] <= wd;
    end
  end

  assign busy = clearing;

endmodule

// ===== design/sgd_momentum_update.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// sgd_momentum_update
// Element-wise SGD update with momentum and selectable weight decay.
// ----------------------------------------------------------------------------
// Input stream s_*: one request per weight element (index, weight, gradient,
// Q16.16). Output stream m_*: index, updated weight and a clip flag.
// Configuration is a plain write port (cfg_wen, cfg_index, cfg_wdata); the
// user must write it only while the block holds no request (not enforced).
//
// Pipeline of five registered stages: velocity read and decay product,
// decayed gradient, the two factor products, new velocity with write-back,
// and the output register. One request per cycle is taken as long as the
// output is not stalled and successive requests touch different elements.
// The velocity memory has a single write port written when a request leaves
// the product stage, so a request whose index matches one of the three
// requests ahead of it in the first three stages waits until that write has
// happened.
//
// Reset empties the pipeline and starts a zeroing sweep of every entry of the
// velocity memory, during which s_tready is low. When m_tready is low the
// stages fill up behind the output register; up to five requests are held
// before s_tready drops.
// ----------------------------------------------------------------------------
module sgd_momentum_update #(
  parameter int ELEMENT_COUNT = sgdm_pkg::ELEMENT_COUNT_DEF
) (
  input  logic                             clk,
  input  logic                             rst,
  // configuration write port
  input  logic                             cfg_wen,
  input  logic [sgdm_pkg::CIDX_W-1:0]      cfg_index,
  input  logic [sgdm_pkg::FAC_W-1:0]       cfg_wdata,
  // input stream
  input  logic                             s_tvalid,
  output logic                             s_tready,
  // element_index[11:0], weight_value[43:12], gradient_value[75:44], zero pad
  input  logic [sgdm_pkg::IN_TD_W-1:0]     s_tdata,
  // output stream
  output logic                             m_tvalid,
  input  logic                             m_tready,
  // result_index[11:0], updated_weight[43:12], zero pad
  output logic [sgdm_pkg::OUT_TD_W-1:0]    m_tdata,
  // saturated[0]
  output logic                             m_tuser
);

  localparam int AW    = (ELEMENT_COUNT > 1) ? $clog2(ELEMENT_COUNT) : 1;
  localparam int IDX_W = sgdm_pkg::IDX_W;
  localparam int VAL_W = sgdm_pkg::VAL_W;
  localparam int FAC_W = sgdm_pkg::FAC_W;
  localparam int PROD_W = sgdm_pkg::PROD_W;
  localparam int OUT_PAD = sgdm_pkg::OUT_TD_W - IDX_W - VAL_W;

  // configuration registers
  logic [FAC_W-1:0]      learning_rate;
  logic [FAC_W-1:0]      momentum_factor;
  logic [FAC_W-1:0]      decay_factor;
  sgdm_pkg::reg_mode_t   regularize_mode;

  always_ff @(posedge clk) begin
    if (rst) begin
      learning_rate   <= sgdm_pkg::LR_RST;
      momentum_factor <= sgdm_pkg::MOM_RST;
      decay_factor    <= sgdm_pkg::DECAY_RST;
      regularize_mode <= sgdm_pkg::REG_L2;
    end else if (cfg_wen) begin
      unique case (sgdm_pkg::cfg_idx_t'(cfg_index))
        sgdm_pkg::CFG_LR:    learning_rate   <= cfg_wdata;
        sgdm_pkg::CFG_MOM:   momentum_factor <= cfg_wdata;
        sgdm_pkg::CFG_DECAY: decay_factor    <= cfg_wdata;
        sgdm_pkg::CFG_MODE:
          regularize_mode <= sgdm_pkg::reg_mode_t'(cfg_wdata[sgdm_pkg::MODE_W-1:0]);
        default: ;
      endcase
    end
  end

  // input fields
  logic [IDX_W-1:0]        in_idx;
  logic signed [VAL_W-1:0] in_w;
  logic signed [VAL_W-1:0] in_g;
  logic [AW-1:0]           in_addr;
  logic                    in_range;

  assign in_idx   = s_tdata[IDX_W-1:0];
  assign in_w     = $signed(s_tdata[IDX_W+VAL_W-1:IDX_W]);
  assign in_g     = $signed(s_tdata[IDX_W+2*VAL_W-1:IDX_W+VAL_W]);
  assign in_addr  = AW'(in_idx);
  assign in_range = (32'(in_idx) < 32'(ELEMENT_COUNT));

  // stage registers
  logic                     a_v, b_v, c_v, d_v, e_v;
  logic [IDX_W-1:0]         a_idx, b_idx, c_idx, d_idx, e_idx;
  logic                     a_range, b_range, c_range;
  logic signed [VAL_W-1:0]  a_w, b_w, c_w, d_w;
  logic signed [VAL_W-1:0]  a_g;
  logic signed [PROD_W-1:0] a_l2prod;
  logic signed [VAL_W-1:0]  b_gd, b_vold;
  logic                     b_clip, c_clip, d_clip, e_clip;
  logic signed [PROD_W-1:0] c_plr, c_pmom;
  logic signed [VAL_W-1:0]  d_vn;
  logic signed [VAL_W-1:0]  e_res;

  // stage enables: a stage loads when empty or when the next one moves on
  logic en_a, en_b, en_c, en_d, en_e;
  logic hazard, busy, accept;

  assign en_e = !e_v || m_tready;
  assign en_d = !d_v || en_e;
  assign en_c = !c_v || en_d;
  assign en_b = !b_v || en_c;
  assign en_a = !a_v || en_b;

  // same element still waiting for its write-back
  assign hazard = (a_v && (a_idx == in_idx)) ||
                  (b_v && (b_idx == in_idx)) ||
                  (c_v && (c_idx == in_idx));

  assign s_tready = en_a && !hazard && !busy;
  assign accept   = s_tvalid && s_tready;

  // velocity memory
  logic [VAL_W-1:0]        rd_data;
  logic                    wr_en;
  logic [AW-1:0]           c_addr;
  sgdm_pkg::sat_t          vn_sat;

  assign c_addr = AW'(c_idx);
  assign wr_en  = c_v && en_d && c_range;

  sgdm_vel_store #(
    .ELEMENT_COUNT (ELEMENT_COUNT),
    .AW            (AW)
  ) u_store (
    .clk     (clk),
    .rst     (rst),
    .rd_en   (accept),
    .rd_addr (in_addr),
    .rd_data (rd_data),
    .wr_en   (wr_en),
    .wr_addr (c_addr),
    .wr_data (vn_sat.value),
    .busy    (busy)
  );

  // stage a: decay product, memory read in flight
  logic signed [PROD_W-1:0] l2prod_next;
  assign l2prod_next = $signed({1'b0, decay_factor}) * in_w;

  always_ff @(posedge clk) begin
    if (rst) begin
      a_v <= 1'b0;
    end else if (en_a) begin
      a_v <= accept;
    end
  end

  always_ff @(posedge clk) begin
    if (en_a) begin
      a_idx    <= in_idx;
      a_range  <= in_range;
      a_w      <= in_w;
      a_g      <= in_g;
      a_l2prod <= l2prod_next;
    end
  end

  // stage b: decayed gradient
  logic signed [FAC_W:0]    l1_term;
  logic signed [PROD_W:0]   l2_sum;
  logic signed [PROD_W-16:0] l2_term;
  logic signed [PROD_W-13:0] gd_sum;
  logic                     use_l1, use_l2;
  sgdm_pkg::sat_t           gd_sat;

  always_comb begin
    use_l1 = (regularize_mode == sgdm_pkg::REG_L1) ||
             (regularize_mode == sgdm_pkg::REG_L1L2);
    use_l2 = (regularize_mode == sgdm_pkg::REG_L2) ||
             (regularize_mode == sgdm_pkg::REG_L1L2);
    // decay times sign of the weight
    priority if (!use_l1 || (a_w == '0)) begin
      l1_term = '0;
    end else if (a_w[VAL_W-1]) begin
      l1_term = -$signed({1'b0, decay_factor});
    end else begin
      l1_term = $signed({1'b0, decay_factor});
    end
    // decay times weight, rounded half up
    l2_sum  = (PROD_W+1)'(a_l2prod) + (PROD_W+1)'(32768);
    l2_term = use_l2 ? l2_sum[PROD_W:16] : '0;
    gd_sum  = (PROD_W-12)'(a_g) + (PROD_W-12)'(l1_term) + (PROD_W-12)'(l2_term);
    gd_sat  = sgdm_pkg::sat32(64'(gd_sum));
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      b_v <= 1'b0;
    end else if (en_b) begin
      b_v <= a_v;
    end
  end

  always_ff @(posedge clk) begin
    if (en_b) begin
      b_idx   <= a_idx;
      b_range <= a_range;
      b_w     <= a_w;
      b_gd    <= gd_sat.value;
      b_clip  <= gd_sat.clip;
      b_vold  <= a_range ? $signed(rd_data) : '0;
    end
  end

  // stage c: rate and momentum products
  always_ff @(posedge clk) begin
    if (rst) begin
      c_v <= 1'b0;
    end else if (en_c) begin
      c_v <= b_v;
    end
  end

  always_ff @(posedge clk) begin
    if (en_c) begin
      c_idx   <= b_idx;
      c_range <= b_range;
      c_w     <= b_w;
      c_clip  <= b_clip;
      c_plr   <= $signed({1'b0, learning_rate}) * b_gd;
      c_pmom  <= $signed({1'b0, momentum_factor}) * b_vold;
    end
  end

  // stage d: new velocity, written back as the request leaves stage c
  logic signed [PROD_W:0] v_sum;
  always_comb begin
    v_sum  = (PROD_W+1)'(c_plr) + (PROD_W+1)'(c_pmom) + (PROD_W+1)'(32768);
    vn_sat = sgdm_pkg::sat32(64'($signed(v_sum[PROD_W:16])));
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      d_v <= 1'b0;
    end else if (en_d) begin
      d_v <= c_v;
    end
  end

  always_ff @(posedge clk) begin
    if (en_d) begin
      d_idx  <= c_idx;
      d_w    <= c_w;
      d_vn   <= vn_sat.value;
      d_clip <= c_clip || vn_sat.clip;
    end
  end

  // stage e: weight minus velocity into the output register
  logic signed [VAL_W:0] diff;
  sgdm_pkg::sat_t        res_sat;
  always_comb begin
    diff    = (VAL_W+1)'(d_w) - (VAL_W+1)'(d_vn);
    res_sat = sgdm_pkg::sat32(64'(diff));
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      e_v <= 1'b0;
    end else if (en_e) begin
      e_v <= d_v;
    end
  end

  always_ff @(posedge clk) begin
    if (en_e) begin
      e_idx  <= d_idx;
      e_res  <= res_sat.value;
      e_clip <= d_clip || res_sat.clip;
    end
  end

  // output stream
  assign m_tvalid = e_v;
  assign m_tdata  = {{OUT_PAD{1'b0}}, e_res, e_idx};
  assign m_tuser  = e_clip;

endmodule

// ===== design/sgdm_checker.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// sgdm_checker
// Port-level checks on the momentum update engine, bound to the top level.
// ----------------------------------------------------------------------------
module sgdm_checker (
  input logic                          clk,
  input logic                          rst,
  input logic                          s_tvalid,
  input logic                          s_tready,
  input logic                          m_tvalid,
  input logic                          m_tready,
  input logic [sgdm_pkg::OUT_TD_W-1:0] m_tdata,
  input logic                          m_tuser
);

  // requests taken but not yet delivered
  logic [2:0] in_flight;
  logic       in_acc, out_acc;

  assign in_acc  = s_tvalid && s_tready;
  assign out_acc = m_tvalid && m_tready;

  always_ff @(posedge clk) begin
    if (rst) begin
      in_flight <= '0;
    end else if (in_acc && !out_acc) begin
      in_flight <= in_flight + 3'd1;
    end else if (out_acc && !in_acc) begin
      in_flight <= in_flight - 3'd1;
    end
  end

  // reset empties the output and starts the clearing sweep
  a_reset_quiet: assert property (@(posedge clk)
    rst |=> !s_tready && !m_tvalid)
    else $error("request path active right after reset");

  // no result without a request behind it
  a_no_invented: assert property (@(posedge clk) disable iff (rst)
    m_tvalid |-> in_flight != 3'd0)
    else $error("result shown with no request in flight");

  // the pipeline holds at most five requests
  a_depth: assert property (@(posedge clk) disable iff (rst)
    in_flight <= 3'd5)
    else $error("more requests in flight than pipeline stages");

  // a stalled result holds
  a_hold: assert property (@(posedge clk) disable iff (rst)
    m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata) && $stable(m_tuser))
    else $error("stalled result changed");

endmodule

bind sgd_momentum_update sgdm_checker u_checker (
  .clk      (clk),
  .rst      (rst),
  .s_tvalid (s_tvalid),
  .s_tready (s_tready),
  .m_tvalid (m_tvalid),
  .m_tready (m_tready),
  .m_tdata  (m_tdata),
  .m_tuser  (m_tuser)
);

// ===== tb/sgd_momentum_update_checker.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// sgd_momentum_update_checker
// Watches the configuration port and both streams of the momentum update
// engine. It keeps its own copy of the registers and of the velocity memory,
// works out each element's update and compares it with the result stream.
// ----------------------------------------------------------------------------
module sgd_momentum_update_checker (
  input  logic                          clk,
  input  logic                          rst,
  input  logic                          cfg_wen,
  input  logic [sgdm_pkg::CIDX_W-1:0]   cfg_index,
  input  logic [sgdm_pkg::FAC_W-1:0]    cfg_wdata,
  input  logic                          s_tvalid,
  input  logic                          s_tready,
  input  logic [sgdm_pkg::IN_TD_W-1:0]  s_tdata,
  input  logic                          m_tvalid,
  input  logic                          m_tready,
  input  logic [sgdm_pkg::OUT_TD_W-1:0] m_tdata,
  input  logic                          m_tuser,
  output int                            mismatches,
  output int                            outstanding
);
  import sgdm_pkg::*;

  localparam longint Q_MAX = 64'sd2147483647;
  localparam longint Q_MIN = -64'sd2147483648;

  typedef struct packed {
    logic [IDX_W-1:0] index;
    logic [VAL_W-1:0] weight;
    logic             clip;
  } weight_update_t;

  // mirrored registers and velocity memory
  logic [FAC_W-1:0] rate_q;
  logic [FAC_W-1:0] momentum_q;
  logic [FAC_W-1:0] decay_q;
  reg_mode_t        mode_q;
  logic [VAL_W-1:0] velocity_mirror [0:ELEMENT_COUNT_DEF-1];

  weight_update_t pending_updates [$];
  weight_update_t want;

  function automatic longint round_q16(input longint x);
    return (x + 64'sd32768) >>> 16;
  endfunction

  function automatic bit clips_q16(input longint x);
    return (x > Q_MAX) || (x < Q_MIN);
  endfunction

  function automatic longint limit_q16(input longint x);
    if (x > Q_MAX) return Q_MAX;
    if (x < Q_MIN) return Q_MIN;
    return x;
  endfunction

  // decayed gradient, new velocity with write-back, clipped weight
  function automatic weight_update_t predict_update(input logic [IDX_W-1:0] idx,
                                                    input logic [VAL_W-1:0] w_bits,
                                                    input logic [VAL_W-1:0] g_bits);
    longint         w;
    longint         d;
    longint         grad;
    longint         acc;
    longint         vel;
    longint         res;
    bit             clip;
    weight_update_t u;
    w    = longint'($signed(w_bits));
    d    = longint'(decay_q);
    grad = longint'($signed(g_bits));
    if (mode_q == REG_L1 || mode_q == REG_L1L2) begin
      if (w > 0) grad = grad + d;
      else if (w < 0) grad = grad - d;
    end
    if (mode_q == REG_L2 || mode_q == REG_L1L2) grad = grad + round_q16(d * w);
    clip = clips_q16(grad);
    grad = limit_q16(grad);
    acc  = longint'(rate_q) * grad
         + longint'(momentum_q) * longint'($signed(velocity_mirror[idx]));
    vel  = round_q16(acc);
    clip = clip | clips_q16(vel);
    vel  = limit_q16(vel);
    velocity_mirror[idx] = vel[VAL_W-1:0];
    res  = w - vel;
    clip = clip | clips_q16(res);
    res  = limit_q16(res);
    u.index  = idx;
    u.weight = res[VAL_W-1:0];
    u.clip   = clip;
    return u;
  endfunction

  always @(posedge clk) begin
    if (rst) begin
      rate_q     = LR_RST;
      momentum_q = MOM_RST;
      decay_q    = DECAY_RST;
      mode_q     = REG_L2;
      for (int i = 0; i < ELEMENT_COUNT_DEF; i++) velocity_mirror[i] = '0;
      pending_updates.delete();
    end else begin
      // register writes
      if (cfg_wen) begin
        case (cfg_idx_t'(cfg_index))
          CFG_LR:    rate_q     = cfg_wdata;
          CFG_MOM:   momentum_q = cfg_wdata;
          CFG_DECAY: decay_q    = cfg_wdata;
          CFG_MODE:  mode_q     = reg_mode_t'(cfg_wdata[MODE_W-1:0]);
          default: ;
        endcase
      end
      // compare each result with the oldest prediction
      if (m_tvalid && m_tready) begin
        if (pending_updates.size() == 0) begin
          mismatches++;
          $display("%0t: result with nothing expected, index %0d weight %h sat %b",
                   $time, m_tdata[11:0], m_tdata[43:12], m_tuser);
        end else begin
          want = pending_updates.pop_front();
          if (m_tdata[11:0] !== want.index) begin
            mismatches++;
            $display("%0t: result_index expected %0d actual %0d",
                     $time, want.index, m_tdata[11:0]);
          end
          if (m_tdata[43:12] !== want.weight) begin
            mismatches++;
            $display("%0t: updated_weight (index %0d) expected %h actual %h",
                     $time, want.index, want.weight, m_tdata[43:12]);
          end
          if (m_tuser !== want.clip) begin
            mismatches++;
            $display("%0t: saturated (index %0d) expected %b actual %b",
                     $time, want.index, want.clip, m_tuser);
          end
        end
      end
      // each accepted request owes one result
      if (s_tvalid && s_tready)
        pending_updates.push_back(predict_update(s_tdata[11:0], s_tdata[43:12],
                                                 s_tdata[75:44]));
    end
    outstanding <= pending_updates.size();
  end

endmodule

// ===== tb/sgd_momentum_update_test.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// sgd_momentum_update_test
// Drives the momentum update engine with directed corner requests and then
// random phases, each under its own register setting, with random gaps on
// the request side and random stalls on the result side. The checker beside
// the block predicts and compares every result.
// ----------------------------------------------------------------------------
module sgd_momentum_update_test;
  import sgdm_pkg::*;

  localparam logic [VAL_W-1:0] Q_MAX  = 32'h7FFF_FFFF;
  localparam logic [VAL_W-1:0] Q_MIN  = 32'h8000_0000;
  localparam logic [VAL_W-1:0] Q_ONE  = 32'h0001_0000;
  localparam int               PHASES = 6;
  localparam int               PER_PHASE = 75;

  logic                  clk;
  logic                  rst;
  logic                  cfg_wen;
  logic [CIDX_W-1:0]     cfg_index;
  logic [FAC_W-1:0]      cfg_wdata;
  logic                  s_tvalid;
  logic                  s_tready;
  logic [IN_TD_W-1:0]    s_tdata;
  logic                  m_tvalid;
  logic                  m_tready;
  logic [OUT_TD_W-1:0]   m_tdata;
  logic                  m_tuser;
  int                    mismatches;
  int                    outstanding;
  bit                    source_calm;
  bit                    sink_calm;

  sgd_momentum_update DUT (
    .clk       (clk),
    .rst       (rst),
    .cfg_wen   (cfg_wen),
    .cfg_index (cfg_index),
    .cfg_wdata (cfg_wdata),
    .s_tvalid  (s_tvalid),
    .s_tready  (s_tready),
    .s_tdata   (s_tdata),
    .m_tvalid  (m_tvalid),
    .m_tready  (m_tready),
    .m_tdata   (m_tdata),
    .m_tuser   (m_tuser)
  );

  sgd_momentum_update_checker checker_i (
    .clk         (clk),
    .rst         (rst),
    .cfg_wen     (cfg_wen),
    .cfg_index   (cfg_index),
    .cfg_wdata   (cfg_wdata),
    .s_tvalid    (s_tvalid),
    .s_tready    (s_tready),
    .s_tdata     (s_tdata),
    .m_tvalid    (m_tvalid),
    .m_tready    (m_tready),
    .m_tdata     (m_tdata),
    .m_tuser     (m_tuser),
    .mismatches  (mismatches),
    .outstanding (outstanding)
  );

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  // mostly short gaps, a few long ones
  function automatic int idle_span();
    int pick;
    pick = $urandom_range(0, 99);
    if (pick < 60) return 0;
    if (pick < 90) return $urandom_range(1, 3);
    if (pick < 98) return $urandom_range(4, 10);
    return $urandom_range(20, 60);
  endfunction

  function automatic logic [VAL_W-1:0] rand_q16();
    case ($urandom_range(0, 9))
      0: begin
        case ($urandom_range(0, 4))
          0: return Q_MAX;
          1: return Q_MIN;
          2: return '0;
          3: return 32'd1;
          default: return '1;
        endcase
      end
      1, 2: return $urandom();
      // realistic magnitudes, within +-8.0
      default: return 32'($urandom_range(0, 1048575) - 524288);
    endcase
  endfunction

  function automatic logic [FAC_W-1:0] rand_factor();
    case ($urandom_range(0, 5))
      0: return '0;
      1: return '1;
      2, 3: return 16'($urandom());
      default: return 16'($urandom_range(0, 2047));
    endcase
  endfunction

  function automatic logic [IDX_W-1:0] rand_index();
    case ($urandom_range(0, 9))
      // a few hot elements so velocities build up and requests collide
      0, 1, 2, 3, 4: return 12'($urandom_range(0, 7));
      5, 6: return 12'($urandom_range(4088, 4095));
      default: return 12'($urandom());
    endcase
  endfunction

  // result side stalls
  initial begin
    int run;
    int off;
    forever begin
      run = $urandom_range(1, 12);
      m_tready <= 1'b1;
      repeat (run) @(posedge clk);
      if (!sink_calm) begin
        off = idle_span();
        if (off > 0) begin
          m_tready <= 1'b0;
          repeat (off) @(posedge clk);
        end
      end
    end
  end

  // one request, held until accepted
  task automatic send_req(input logic [IDX_W-1:0] idx, input logic [VAL_W-1:0] w,
                          input logic [VAL_W-1:0] g);
    int gap;
    gap = source_calm ? 0 : idle_span();
    if (gap > 0) begin
      s_tvalid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    s_tvalid <= 1'b1;
    s_tdata  <= {4'b0, g, w, idx};
    do @(posedge clk); while (!s_tready);
  endtask

  // write all four registers on consecutive cycles
  task automatic program_regs(input logic [FAC_W-1:0] rate, input logic [FAC_W-1:0] mom,
                              input logic [FAC_W-1:0] decay, input logic [FAC_W-1:0] mode_word);
    cfg_wen   <= 1'b1;
    cfg_index <= CFG_LR;
    cfg_wdata <= rate;
    @(posedge clk);
    cfg_index <= CFG_MOM;
    cfg_wdata <= mom;
    @(posedge clk);
    cfg_index <= CFG_DECAY;
    cfg_wdata <= decay;
    @(posedge clk);
    cfg_index <= CFG_MODE;
    cfg_wdata <= mode_word;
    @(posedge clk);
    cfg_wen <= 1'b0;
  endtask

  // let every result come out before the next setting
  task automatic drain();
    s_tvalid <= 1'b0;
    @(posedge clk);
    while (outstanding != 0) @(posedge clk);
    repeat (8) @(posedge clk);
  endtask

  initial begin
    logic [FAC_W-1:0] mode_word;
    rst         <= 1'b1;
    cfg_wen     <= 1'b0;
    cfg_index   <= CFG_LR;
    cfg_wdata   <= '0;
    s_tvalid    <= 1'b0;
    s_tdata     <= '0;
    source_calm = 1'b1;
    sink_calm   = 1'b1;
    repeat (5) @(posedge clk);
    rst <= 1'b0;

    // reset setting: extremes of the fields, then back to back on one element
    send_req(12'd0, '0, '0);
    send_req(12'd4095, Q_MAX, Q_MAX);
    send_req(12'd1, Q_MIN, Q_MIN);
    send_req(12'd0, Q_ONE, Q_ONE);
    send_req(12'd0, Q_ONE, Q_ONE);
    send_req(12'd0, -Q_ONE, Q_ONE);
    drain();

    // every factor at full scale, both decay terms: clipping on the extreme requests
    source_calm = 1'b0;
    sink_calm   = 1'b0;
    program_regs('1, '1, '1, {14'h3FFF, REG_L1L2});
    send_req(12'd2, Q_MAX, Q_MAX);
    send_req(12'd3, Q_MIN, Q_MIN);
    send_req(12'd4, '0, 32'h0000_8000);
    send_req(12'd5, '1, '0);
    send_req(12'd6, 32'd1, '0);
    send_req(12'd2, Q_MIN, Q_MAX);
    send_req(12'd2, Q_MAX, Q_MIN);
    drain();

    // no decay term, zero rate and momentum: weight passes through
    program_regs('0, '0, '1, {14'h0, REG_NONE});
    send_req(12'd7, 32'h1234_5678, Q_MAX);
    send_req(12'd4095, Q_MIN, Q_MIN);
    send_req(12'd8, '1, 32'hDEAD_BEEF);
    drain();

    // sign decay only
    program_regs(16'h8000, '0, 16'd1000, {14'h0, REG_L1});
    send_req(12'd9, Q_ONE, '0);
    send_req(12'd9, -Q_ONE, '0);
    send_req(12'd10, '0, Q_ONE);
    send_req(12'd11, Q_MIN, Q_MIN);
    drain();

    // random phases, each with its own setting
    for (int p = 0; p < PHASES; p++) begin
      mode_word   = 16'($urandom());
      source_calm = ($urandom_range(0, 3) == 0);
      sink_calm   = ($urandom_range(0, 3) == 0);
      if (p == 0) program_regs(16'd655, 16'd58982, 16'd66, mode_word);
      else program_regs(rand_factor(), rand_factor(), rand_factor(), mode_word);
      for (int n = 0; n < PER_PHASE; n++) send_req(rand_index(), rand_q16(), rand_q16());
      drain();
    end

    if (mismatches == 0) begin
      $display("sgd_momentum_update verification clean");
    end else begin
      $display("sgd_momentum_update verification failed");
    end
    $finish;
  end

  // watchdog
  initial begin
    #5_000_000;
    $display("sgd_momentum_update verification failed");
    $finish;
  end

endmodule

// ===== sim.f =====
design/sgdm_pkg.sv
design/sgdm_vel_store.sv
design/sgd_momentum_update.sv
design/sgdm_checker.sv
tb/sgd_momentum_update_checker.sv
tb/sgd_momentum_update_test.sv
